[rtl/xst_pkg.sv]
// ----------------------------------------------------------------------------
// xst_pkg
// Shared types and constants of the streaming XML tokenizer.
// ----------------------------------------------------------------------------
package xst_pkg;

    localparam int PREFIX_DEPTH = 8;

    localparam logic [2:0] K_TEXT  = 3'd0;
    localparam logic [2:0] K_CDATA = 3'd1;
    localparam logic [2:0] K_START = 3'd2;
    localparam logic [2:0] K_END   = 3'd3;
    localparam logic [2:0] K_ANAME = 3'd4;
    localparam logic [2:0] K_AVAL  = 3'd5;

    localparam logic [2:0] E_DATA    = 3'd0;
    localparam logic [2:0] E_TEXTEND = 3'd1;
    localparam logic [2:0] E_ATTR    = 3'd2;
    localparam logic [2:0] E_START   = 3'd3;
    localparam logic [2:0] E_ENDTAG  = 3'd4;
    localparam logic [2:0] E_SELF    = 3'd5;
    localparam logic [2:0] E_DOC     = 3'd6;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;

    localparam logic [7:0] PAT_COM [4] = '{8'h21, 8'h2D, 8'h2D, 8'h00};
    localparam logic [7:0] PAT_CD  [8] = '{8'h21, 8'h5B, 8'h43, 8'h44,
                                           8'h41, 8'h54, 8'h41, 8'h5B};
    localparam logic [7:0] PAT_DT  [8] = '{8'h21, 8'h44, 8'h4F, 8'h43,
                                           8'h54, 8'h59, 8'h50, 8'h45};

    typedef enum logic [4:0] {
        M_TEXT       = 5'd0,
        M_PREFIX     = 5'd1,
        M_COMMENT    = 5'd2,
        M_CDATA      = 5'd3,
        M_PI         = 5'd4,
        M_DOCTYPE    = 5'd5,
        M_DTD_INT    = 5'd6,
        M_TAG_OPEN   = 5'd7,
        M_END_OPEN   = 5'd8,
        M_END_NAME   = 5'd9,
        M_SKIP       = 5'd10,
        M_START_NAME = 5'd11,
        M_ATTR_GAP   = 5'd12,
        M_AK_NAME    = 5'd13,
        M_AK_AFTER   = 5'd14,
        M_AK_VSTART  = 5'd15,
        M_AK_QUOTED  = 5'd16,
        M_AK_UNQ     = 5'd17,
        M_AD_NAME    = 5'd18,
        M_AD_AFTER   = 5'd19,
        M_AD_VSTART  = 5'd20,
        M_AD_QUOTED  = 5'd21,
        M_AD_UNQ     = 5'd22
    } mode_t;

    typedef enum logic [1:0] {
        PH_FEED,
        PH_REPLAY,
        PH_FIN
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] lower;
        logic       ws;
    } cls_t;

    typedef struct packed {
        cls_t c;
        logic last;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] kind;
        logic [2:0] ev;
    } res_t;

endpackage

[rtl/xst_front.sv]
// ----------------------------------------------------------------------------
// xst_front
// Input side: accepts bytes, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module xst_front import xst_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output head_t      head,
    input  logic       pop
);

    item_t      q_reg [4];
    logic [1:0] wp_reg;
    logic [1:0] rp_reg;
    logic [2:0] cnt_reg;
    item_t      nitem;
    logic       push;

    always_comb
    begin
        nitem.c.data  = in_byte;
        nitem.c.lower = (in_byte >= CH_UA && in_byte <= CH_UZ) ? in_byte + 8'd32 : in_byte;
        nitem.c.ws    = (in_byte == CH_SP) || (in_byte == CH_TAB) ||
                        (in_byte == CH_LF) || (in_byte == CH_CR);
        nitem.last    = in_last;
    end

    assign in_ready   = (cnt_reg != 3'd4);
    assign push       = in_valid && in_ready;
    assign head.valid = (cnt_reg != 3'd0);
    assign head.item  = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= nitem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 2'd1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + {2'b0, push} - {2'b0, pop};
        end
    end

endmodule

[rtl/xst_back.sv]
// ----------------------------------------------------------------------------
// xst_back
// Mode machine: consumes queued bytes, sequences results one per cycle unless
// out_ready stalls, replays held prefix bytes and closes the document.
// ----------------------------------------------------------------------------
module xst_back import xst_pkg::*; #(
    parameter int MAX_ATTRIBUTES = 50
) (
    input  logic       clk,
    input  logic       rst_n,
    input  head_t      head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [2:0] kind,
    output logic [2:0] event_res,
    output logic       out_last
);

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  tm;
        logic        qs;
        logic [7:0]  ac;
        logic        tp;
        logic [3:0]  pc;
        logic        fc;
        logic        fcd;
        logic        fdt;
    } ctx_t;

    typedef struct packed {
        logic [2:0]       n;
        res_t [3:0]       r;
        ctx_t             s;
    } fo_t;

    localparam ctx_t CTX_RST = '{mode: M_TEXT, default: '0};

    function automatic fo_t push_r(fo_t oi, logic [7:0] d, logic [2:0] k, logic [2:0] e);
        fo_t o;
        o = oi;
        o.r[o.n[1:0]] = '{data: d, kind: k, ev: e};
        o.n = o.n + 3'd1;
        return o;
    endfunction

    function automatic mode_t amode(logic [2:0] sub, logic keep);
        return mode_t'(5'd13 + {2'b0, sub} + (keep ? 5'd0 : 5'd5));
    endfunction

    function automatic fo_t tag_close(fo_t oi, logic [7:0] d);
        fo_t o;
        o = push_r(oi, 8'd0, K_START, E_START);
        if (d == CH_SLASH)
        begin
            o = push_r(o, 8'd0, K_END, E_SELF);
            o.s.mode = M_SKIP;
        end
        else
        begin
            o.s.mode = M_TEXT;
        end
        return o;
    endfunction

    function automatic fo_t attr_done(fo_t oi, logic keep);
        fo_t o;
        o = oi;
        if (keep)
        begin
            o = push_r(o, 8'd0, K_AVAL, E_ATTR);
        end
        return o;
    endfunction

    function automatic fo_t gap_byte(fo_t oi, cls_t c);
        fo_t  o;
        logic keep;
        o = oi;
        keep = o.s.ac < 8'(MAX_ATTRIBUTES);
        if (c.ws || c.data == CH_EQ)
        begin
            o.s.mode = M_ATTR_GAP;
        end
        else if (c.data == CH_SLASH || c.data == CH_GT)
        begin
            o = tag_close(o, c.data);
        end
        else
        begin
            if (keep)
            begin
                o.s.ac = o.s.ac + 8'd1;
                o = push_r(o, c.lower, K_ANAME, E_DATA);
            end
            o.s.mode = amode(3'd0, keep);
        end
        return o;
    endfunction

    function automatic fo_t flush_br(fo_t oi);
        fo_t o;
        o = oi;
        if (o.s.tm >= 2'd1)
        begin
            o = push_r(o, CH_RBRK, K_CDATA, E_DATA);
            o.s.tp = 1'b1;
        end
        if (o.s.tm >= 2'd2)
        begin
            o = push_r(o, CH_RBRK, K_CDATA, E_DATA);
        end
        o.s.tm = 2'd0;
        return o;
    endfunction

    function automatic fo_t feed_other(ctx_t si, cls_t c);
        fo_t        o;
        logic [4:0] rel;
        logic       keep;
        logic [2:0] sub;
        logic       cls;
        logic [7:0] d;
        o.n = '0;
        o.r = '0;
        o.s = si;
        d = c.data;
        rel = 5'(si.mode) - 5'd13;
        keep = rel < 5'd5;
        sub = keep ? rel[2:0] : 3'(rel - 5'd5);
        cls = (d == CH_SLASH) || (d == CH_GT);
        case (si.mode)
            M_TEXT:
            begin
                if (d == CH_LT)
                begin
                    if (si.tp)
                    begin
                        o = push_r(o, 8'd0, K_TEXT, E_TEXTEND);
                    end
                    o.s.tp = 1'b0;
                    o.s.pc = 4'd0;
                    o.s.fc = 1'b1;
                    o.s.fcd = 1'b1;
                    o.s.fdt = 1'b1;
                    o.s.mode = M_PREFIX;
                end
                else
                begin
                    o = push_r(o, d, K_TEXT, E_DATA);
                    o.s.tp = 1'b1;
                end
            end
            M_COMMENT:
            begin
                if (d == CH_DASH)
                begin
                    if (si.tm < 2'd2)
                    begin
                        o.s.tm = si.tm + 2'd1;
                    end
                end
                else if (d == CH_GT && si.tm == 2'd2)
                begin
                    o.s.tm = 2'd0;
                    o.s.mode = M_TEXT;
                end
                else
                begin
                    o.s.tm = 2'd0;
                end
            end
            M_PI, M_DTD_INT:
            begin
                if (d == ((si.mode == M_PI) ? CH_QUEST : CH_RBRK))
                begin
                    o.s.tm = 2'd1;
                end
                else if (d == CH_GT && si.tm == 2'd1)
                begin
                    o.s.tm = 2'd0;
                    o.s.mode = M_TEXT;
                end
                else
                begin
                    o.s.tm = 2'd0;
                end
            end
            M_DOCTYPE:
            begin
                if (d == CH_LBRK)
                begin
                    o.s.tm = 2'd0;
                    o.s.mode = M_DTD_INT;
                end
                else if (d == CH_GT)
                begin
                    o.s.mode = M_TEXT;
                end
            end
            M_CDATA:
            begin
                if (d == CH_RBRK)
                begin
                    if (si.tm < 2'd2)
                    begin
                        o.s.tm = si.tm + 2'd1;
                    end
                    else
                    begin
                        o = push_r(o, CH_RBRK, K_CDATA, E_DATA);
                        o.s.tp = 1'b1;
                    end
                end
                else if (d == CH_GT && si.tm == 2'd2)
                begin
                    if (si.tp)
                    begin
                        o = push_r(o, 8'd0, K_CDATA, E_TEXTEND);
                    end
                    o.s.tp = 1'b0;
                    o.s.tm = 2'd0;
                    o.s.mode = M_TEXT;
                end
                else
                begin
                    o = flush_br(o);
                    o = push_r(o, d, K_CDATA, E_DATA);
                    o.s.tp = 1'b1;
                end
            end
            M_TAG_OPEN:
            begin
                if (!c.ws)
                begin
                    if (d == CH_SLASH)
                    begin
                        o.s.mode = M_END_OPEN;
                    end
                    else if (d == CH_GT)
                    begin
                        o.s.mode = M_TEXT;
                    end
                    else
                    begin
                        o.s.ac = 8'd0;
                        o = push_r(o, c.lower, K_START, E_DATA);
                        o.s.mode = M_START_NAME;
                    end
                end
            end
            M_END_OPEN:
            begin
                if (!c.ws)
                begin
                    if (d == CH_SLASH)
                    begin
                        o.s.mode = M_SKIP;
                    end
                    else if (d == CH_GT)
                    begin
                        o.s.mode = M_TEXT;
                    end
                    else
                    begin
                        o = push_r(o, c.lower, K_END, E_DATA);
                        o.s.mode = M_END_NAME;
                    end
                end
            end
            M_END_NAME:
            begin
                if (c.ws || d == CH_SLASH)
                begin
                    o = push_r(o, 8'd0, K_END, E_ENDTAG);
                    o.s.mode = M_SKIP;
                end
                else if (d == CH_GT)
                begin
                    o = push_r(o, 8'd0, K_END, E_ENDTAG);
                    o.s.mode = M_TEXT;
                end
                else
                begin
                    o = push_r(o, c.lower, K_END, E_DATA);
                end
            end
            M_SKIP:
            begin
                if (d == CH_GT)
                begin
                    o.s.mode = M_TEXT;
                end
            end
            M_START_NAME:
            begin
                if (c.ws)
                begin
                    o.s.mode = M_ATTR_GAP;
                end
                else if (cls)
                begin
                    o = tag_close(o, d);
                end
                else
                begin
                    o = push_r(o, c.lower, K_START, E_DATA);
                end
            end
            M_ATTR_GAP:
            begin
                o = gap_byte(o, c);
            end
            M_AK_NAME, M_AK_AFTER, M_AK_VSTART, M_AK_QUOTED, M_AK_UNQ,
            M_AD_NAME, M_AD_AFTER, M_AD_VSTART, M_AD_QUOTED, M_AD_UNQ:
            begin
                case (sub)
                    3'd0:
                    begin
                        if (c.ws)
                        begin
                            o.s.mode = amode(3'd1, keep);
                        end
                        else if (d == CH_EQ)
                        begin
                            o.s.mode = amode(3'd2, keep);
                        end
                        else if (cls)
                        begin
                            o = attr_done(o, keep);
                            o = tag_close(o, d);
                        end
                        else if (keep)
                        begin
                            o = push_r(o, c.lower, K_ANAME, E_DATA);
                        end
                    end
                    3'd1:
                    begin
                        if (d == CH_EQ)
                        begin
                            o.s.mode = amode(3'd2, keep);
                        end
                        else if (!c.ws)
                        begin
                            o = attr_done(o, keep);
                            o = gap_byte(o, c);
                        end
                    end
                    3'd2:
                    begin
                        if (c.ws || d == CH_EQ)
                        begin
                            o.s.mode = si.mode;
                        end
                        else if (d == CH_DQ || d == CH_SQ)
                        begin
                            o.s.qs = (d == CH_SQ);
                            o.s.mode = amode(3'd3, keep);
                        end
                        else if (cls)
                        begin
                            o = attr_done(o, keep);
                            o = tag_close(o, d);
                        end
                        else
                        begin
                            if (keep)
                            begin
                                o = push_r(o, d, K_AVAL, E_DATA);
                            end
                            o.s.mode = amode(3'd4, keep);
                        end
                    end
                    3'd3:
                    begin
                        if (d == (si.qs ? CH_SQ : CH_DQ))
                        begin
                            o = attr_done(o, keep);
                            o.s.mode = M_ATTR_GAP;
                        end
                        else if (keep)
                        begin
                            o = push_r(o, d, K_AVAL, E_DATA);
                        end
                    end
                    default:
                    begin
                        if (c.ws)
                        begin
                            o = attr_done(o, keep);
                            o.s.mode = M_ATTR_GAP;
                        end
                        else if (cls)
                        begin
                            o = attr_done(o, keep);
                            o = tag_close(o, d);
                        end
                        else if (keep)
                        begin
                            o = push_r(o, d, K_AVAL, E_DATA);
                        end
                    end
                endcase
            end
            default:
            begin
                o.s.mode = M_TEXT;
            end
        endcase
        return o;
    endfunction

    function automatic fo_t fin_list(ctx_t si);
        fo_t o;
        o.n = '0;
        o.r = '0;
        o.s = si;
        case (si.mode)
            M_TEXT:
            begin
                if (si.tp)
                begin
                    o = push_r(o, 8'd0, K_TEXT, E_TEXTEND);
                end
            end
            M_CDATA:
            begin
                o = flush_br(o);
                if (o.s.tp)
                begin
                    o = push_r(o, 8'd0, K_CDATA, E_TEXTEND);
                end
            end
            M_END_NAME:
            begin
                o = push_r(o, 8'd0, K_END, E_ENDTAG);
            end
            M_START_NAME, M_ATTR_GAP:
            begin
                o = push_r(o, 8'd0, K_START, E_START);
            end
            M_AK_NAME, M_AK_AFTER, M_AK_VSTART, M_AK_QUOTED, M_AK_UNQ:
            begin
                o = push_r(o, 8'd0, K_AVAL, E_ATTR);
                o = push_r(o, 8'd0, K_START, E_START);
            end
            M_AD_NAME, M_AD_AFTER, M_AD_VSTART, M_AD_QUOTED, M_AD_UNQ:
            begin
                o = push_r(o, 8'd0, K_START, E_START);
            end
            default:
            begin
                o.s = si;
            end
        endcase
        o = push_r(o, 8'd0, K_TEXT, E_DOC);
        o.s = CTX_RST;
        return o;
    endfunction

    ctx_t       ctx_reg, ctx_next;
    phase_t     phase_reg, phase_next;
    cls_t       store_reg [PREFIX_DEPTH];
    logic [1:0] k_reg, k_next;
    logic [2:0] ri_reg, ri_next;
    logic [3:0] rn_reg, rn_next;
    logic       hold_valid_reg, hold_done_reg;
    res_t       hold_res_reg;
    logic       out_valid_reg, out_last_reg;
    res_t       out_res_reg;

    cls_t       cur_c;
    fo_t        fo, fl, lst;
    logic       in_prefix;
    logic       has_emit, emit_ok, emit_fire, step, call_done, hold_push, out_free;
    logic       is_last;
    logic [3:0] pc1;
    logic       fc1, fcd1, fdt1, pq, store_we;
    res_t       cur_res;

    assign is_last   = head.item.last;
    assign cur_c     = (phase_reg == PH_REPLAY) ? store_reg[ri_reg] : head.item.c;
    assign in_prefix = (ctx_reg.mode == M_PREFIX);

    assign pq   = (ctx_reg.pc == 4'd0) && (head.item.c.data == CH_QUEST);
    assign pc1  = ctx_reg.pc + 4'd1;
    assign fc1  = ctx_reg.fc && (ctx_reg.pc < 4'd3) &&
                  (head.item.c.data == PAT_COM[ctx_reg.pc[1:0]]);
    assign fcd1 = ctx_reg.fcd && (head.item.c.data == PAT_CD[ctx_reg.pc[2:0]]);
    assign fdt1 = ctx_reg.fdt && (head.item.c.data == PAT_DT[ctx_reg.pc[2:0]]);

    // result list of the current call
    always_comb
    begin
        fo  = feed_other(ctx_reg, cur_c);
        fl  = fin_list(ctx_reg);
        lst = fo;
        if ((phase_reg == PH_FIN && in_prefix) || (phase_reg == PH_FEED && in_prefix))
        begin
            lst.n = 3'd0;
        end
        else if (phase_reg == PH_FIN)
        begin
            lst = fl;
        end
        cur_res   = lst.r[k_reg];
        out_free  = !out_valid_reg || out_ready;
        has_emit  = head.valid && ({1'b0, k_reg} < lst.n);
        emit_ok   = !hold_valid_reg || out_free;
        step      = head.valid && (!has_emit || emit_ok);
        emit_fire = step && has_emit;
        call_done = step && ((lst.n == 3'd0) || ({1'b0, k_reg} == lst.n - 3'd1));
        hold_push = hold_valid_reg && out_free && (hold_done_reg || emit_fire);
    end

    // sequencer next state
    always_comb
    begin
        ctx_next   = ctx_reg;
        phase_next = phase_reg;
        ri_next    = ri_reg;
        rn_next    = rn_reg;
        pop        = 1'b0;
        store_we   = 1'b0;
        k_next     = k_reg;
        if (emit_fire)
        begin
            k_next = k_reg + 2'd1;
        end
        if (call_done)
        begin
            k_next = 2'd0;
            case (phase_reg)
                PH_FEED:
                begin
                    if (in_prefix)
                    begin
                        if (pq)
                        begin
                            ctx_next.tm   = 2'd1;
                            ctx_next.mode = M_PI;
                        end
                        else
                        begin
                            store_we     = 1'b1;
                            ctx_next.pc  = pc1;
                            ctx_next.fc  = fc1;
                            ctx_next.fcd = fcd1;
                            ctx_next.fdt = fdt1;
                            if (pc1 == 4'd3 && fc1)
                            begin
                                ctx_next.pc   = 4'd0;
                                ctx_next.tm   = 2'd2;
                                ctx_next.mode = M_COMMENT;
                            end
                            else if (pc1 == 4'd8 && fcd1)
                            begin
                                ctx_next.pc   = 4'd0;
                                ctx_next.tm   = 2'd0;
                                ctx_next.tp   = 1'b0;
                                ctx_next.mode = M_CDATA;
                            end
                            else if (pc1 == 4'd8 && fdt1)
                            begin
                                ctx_next.pc   = 4'd0;
                                ctx_next.tm   = 2'd0;
                                ctx_next.mode = M_DOCTYPE;
                            end
                            else if (!(pc1 < 4'd8 && (fc1 || fcd1 || fdt1)))
                            begin
                                ctx_next.pc   = 4'd0;
                                ctx_next.mode = M_TAG_OPEN;
                                rn_next       = pc1;
                                ri_next       = 3'd0;
                                phase_next    = PH_REPLAY;
                            end
                        end
                    end
                    else
                    begin
                        ctx_next = fo.s;
                    end
                    if (phase_next == PH_FEED)
                    begin
                        if (is_last)
                        begin
                            phase_next = PH_FIN;
                        end
                        else
                        begin
                            pop = 1'b1;
                        end
                    end
                end
                PH_REPLAY:
                begin
                    ctx_next = fo.s;
                    if ({1'b0, ri_reg} == rn_reg - 4'd1)
                    begin
                        if (is_last)
                        begin
                            phase_next = PH_FIN;
                        end
                        else
                        begin
                            pop        = 1'b1;
                            phase_next = PH_FEED;
                        end
                    end
                    else
                    begin
                        ri_next = ri_reg + 3'd1;
                    end
                end
                PH_FIN:
                begin
                    if (in_prefix)
                    begin
                        ctx_next.mode = M_TAG_OPEN;
                        ctx_next.pc   = 4'd0;
                        if (ctx_reg.pc != 4'd0)
                        begin
                            rn_next    = ctx_reg.pc;
                            ri_next    = 3'd0;
                            phase_next = PH_REPLAY;
                        end
                    end
                    else
                    begin
                        ctx_next   = fl.s;
                        pop        = 1'b1;
                        phase_next = PH_FEED;
                    end
                end
                default:
                begin
                    phase_next = PH_FEED;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[ctx_reg.pc[2:0]] <= head.item.c;
        end
        if (emit_fire)
        begin
            hold_res_reg <= cur_res;
        end
        if (hold_push)
        begin
            out_res_reg  <= hold_res_reg;
            out_last_reg <= hold_done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg        <= CTX_RST;
            phase_reg      <= PH_FEED;
            k_reg          <= '0;
            ri_reg         <= '0;
            rn_reg         <= '0;
            hold_valid_reg <= 1'b0;
            hold_done_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ctx_reg   <= ctx_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
            ri_reg    <= ri_next;
            rn_reg    <= rn_next;
            if (emit_fire)
            begin
                hold_valid_reg <= 1'b1;
                hold_done_reg  <= pop;
            end
            else if (hold_push)
            begin
                hold_valid_reg <= 1'b0;
                hold_done_reg  <= 1'b0;
            end
            else if (pop && hold_valid_reg)
            begin
                hold_done_reg <= 1'b1;
            end
            if (hold_push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_res_reg.data;
    assign kind      = out_res_reg.kind;
    assign event_res = out_res_reg.ev;
    assign out_last  = out_last_reg;

endmodule

[rtl/xml_sax_tokenizer.sv]
// ----------------------------------------------------------------------------
// xml_sax_tokenizer: streaming XML tokenizer, one byte in, tagged bytes out.
// Bytes pass input queue, hold and output registers; one result per cycle
// unless out_ready stalls. Held prefix bytes are replayed before the queue pops.
// Asynchronous active-low reset clears queue, mode machine and output stage.
// ----------------------------------------------------------------------------
module xml_sax_tokenizer import xst_pkg::*; #(
    parameter int MAX_ATTRIBUTES = 50
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [2:0] kind,
    output logic [2:0] event_res,
    output logic       out_last
);

    head_t head;
    logic  pop;

    xst_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .head     (head),
        .pop      (pop)
    );

    xst_back #(
        .MAX_ATTRIBUTES (MAX_ATTRIBUTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .kind      (kind),
        .event_res (event_res),
        .out_last  (out_last)
    );

`ifndef SYNTHESIS
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid) else $error("pop with empty queue");
    a_doc_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == E_DOC |-> out_last) else $error("doc end not last");
    a_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != E_DATA |-> out_byte == 8'd0) else $error("event byte");
`endif

endmodule
